>>> hw/rtl/i2r_pkg.sv
// Shared constants, types and symbol tables for the Roman numeral converter.
`timescale 1ns / 1ps
`default_nettype none
package i2r_pkg;

	localparam int VALUE_W   = 12;
	localparam int DIGITS    = 4;
	localparam int BCD_W     = 4 * DIGITS;
	localparam int SYM_W     = 7;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 8;
	localparam int COUNT_W   = $clog2(VALUE_W + 1);
	localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(3999);

	localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
	localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;
	localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
	localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
	localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
	localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
	localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
	localparam logic [SYM_W-1:0] SYM_I    = 7'h49;

	typedef enum logic [1:0] {
		KIND_ONE,
		KIND_FIVE,
		KIND_TEN
	} sym_kind_t;

	typedef struct packed {
		logic load;
		logic err;
	} emit_ctl_t;

	// symbols needed to write one decimal digit
	function automatic logic [2:0] digit_len(input logic [3:0] d);
		logic [2:0] n;
		case (d)
			4'd0: n = 3'd0;
			4'd1: n = 3'd1;
			4'd2: n = 3'd2;
			4'd3: n = 3'd3;
			4'd4: n = 3'd2;
			4'd5: n = 3'd1;
			4'd6: n = 3'd2;
			4'd7: n = 3'd3;
			4'd8: n = 3'd4;
			4'd9: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// which symbol of the decade stands at step k of digit d
	function automatic sym_kind_t digit_kind(input logic [3:0] d, input logic [1:0] k);
		sym_kind_t s;
		if (d == 4'd9) begin
			s = (k == 2'd0) ? KIND_ONE : KIND_TEN;
		end else if (d == 4'd4) begin
			s = (k == 2'd0) ? KIND_ONE : KIND_FIVE;
		end else if (d >= 4'd5 && k == 2'd0) begin
			s = KIND_FIVE;
		end else begin
			s = KIND_ONE;
		end
		return s;
	endfunction

	// ASCII symbol for a decade (0 thousands .. 3 units) and kind
	function automatic logic [SYM_W-1:0] decade_sym(input logic [1:0] pos,
		input sym_kind_t kind);
		logic [SYM_W-1:0] c;
		case (pos)
			2'd0: c = SYM_M;
			2'd1: begin
				case (kind)
					KIND_ONE:  c = SYM_C;
					KIND_FIVE: c = SYM_D;
					KIND_TEN:  c = SYM_M;
					default:   c = SYM_NONE;
				endcase
			end
			2'd2: begin
				case (kind)
					KIND_ONE:  c = SYM_X;
					KIND_FIVE: c = SYM_L;
					KIND_TEN:  c = SYM_C;
					default:   c = SYM_NONE;
				endcase
			end
			2'd3: begin
				case (kind)
					KIND_ONE:  c = SYM_I;
					KIND_FIVE: c = SYM_V;
					KIND_TEN:  c = SYM_X;
					default:   c = SYM_NONE;
				endcase
			end
			default: c = SYM_NONE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/i2r_dabble.sv
// Bit-serial binary to BCD converter, one input bit shifted in per cycle.
`timescale 1ns / 1ps
`default_nettype none
module i2r_dabble
	import i2r_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    done,
	output logic [BCD_W-1:0]        digits
);

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               done_q;
	logic [BCD_W-1:0]   adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == COUNT_W'(1));
			if (start) begin
				cnt_q <= COUNT_W'(VALUE_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule
`default_nettype wire

>>> hw/rtl/i2r_emit.sv
// Symbol sequencer: walks the decimal digits and emits one character per word.
`timescale 1ns / 1ps
`default_nettype none
module i2r_emit
	import i2r_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire emit_ctl_t             ctl,
	input  wire logic [BCD_W-1:0]      digits,
	output logic                       busy,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);

	logic [BCD_W-1:0] dig_q;
	logic [1:0]       pos_q;
	logic [1:0]       step_q;
	logic             err_q;
	logic             busy_q;
	logic             valid_q;
	logic [SYM_W-1:0] sym_q;
	logic             last_q;
	logic             rerr_q;

	logic [3:0]       cur;
	logic [2:0]       len;
	logic             slot_free;
	logic             end_digit;
	logic             is_last;
	logic [SYM_W-1:0] sym;

	assign cur       = dig_q[BCD_W-1 -: 4];
	assign len       = digit_len(cur);
	assign slot_free = !valid_q || m_tready;
	assign end_digit = ({1'b0, step_q} == len - 3'd1);
	assign is_last   = end_digit && (dig_q[BCD_W-5:0] == '0);
	assign sym       = decade_sym(pos_q, digit_kind(cur, step_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				busy_q <= 1'b1;
			end else if (busy_q && slot_free && (err_q || (len != 3'd0 && is_last))) begin
				busy_q <= 1'b0;
			end
			if (busy_q && slot_free && (err_q || len != 3'd0)) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dig_q  <= digits;
			pos_q  <= 2'd0;
			step_q <= 2'd0;
			err_q  <= ctl.err;
		end else if (busy_q && slot_free) begin
			if (err_q) begin
				sym_q  <= SYM_NONE;
				last_q <= 1'b1;
				rerr_q <= 1'b1;
			end else if (len == 3'd0) begin
				// skip an empty decade
				dig_q <= {dig_q[BCD_W-5:0], 4'd0};
				pos_q <= pos_q + 2'd1;
			end else begin
				sym_q  <= sym;
				last_q <= is_last;
				rerr_q <= 1'b0;
				if (end_digit) begin
					dig_q  <= {dig_q[BCD_W-5:0], 4'd0};
					pos_q  <= pos_q + 2'd1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_DATA_W-SYM_W){1'b0}}, sym_q};
	assign m_tlast  = last_q;
	assign m_tuser  = rerr_q;

endmodule
`default_nettype wire

>>> hw/rtl/integer_to_roman_numeral.sv
// Top level of the integer to Roman numeral converter.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: value[11:0], zero pad [15:12]
//  m_*       out  m_tvalid/m_tready  m_tdata: symbol[6:0], zero pad [7];
//                                    m_tlast: last; m_tuser: range_error
//
// One value at a time: accept, bit-serial BCD conversion, handoff into the
// sequencer, one character per word plus a skip step for each empty decade
// ahead of the final symbol, then back to idle. The pace is set by the
// conversion shift register and the one-character output register.
// A value out of range still passes the conversion and yields one error word.
// A stalled output holds its word and the sequencer; the next value is taken
// once the last word sits in the output register.
// Reset clears control state only; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_roman_numeral
	import i2r_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // value[11:0], pad[15:12]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // symbol[6:0], pad[7]
	output logic                       m_tlast,
	output logic                       m_tuser    // range_error
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic               err_q;
	emit_ctl_t          ctl_q;
	logic               accept;
	logic [VALUE_W-1:0] value;
	logic               conv_done;
	logic [BCD_W-1:0]   digits;
	logic               emit_busy;

	assign value    = s_tdata[VALUE_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			err_q   <= 1'b0;
			ctl_q   <= '0;
		end else begin
			ctl_q.load <= (state_q == ST_CONV) && conv_done;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						err_q   <= (value == '0) || (value > VALUE_MAX);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv_done) begin
						ctl_q.err  <= err_q;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!ctl_q.load && !emit_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	i2r_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (value),
		.done   (conv_done),
		.digits (digits)
	);

	i2r_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_q),
		.digits   (digits),
		.busy     (emit_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

>>> hw/rtl/i2r_checker.sv
// Port checker for the Roman numeral converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module i2r_checker
	import i2r_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                 m_tlast,
	input wire logic                 m_tuser
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after a word");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
		else $error("range error word malformed");

	a_symbol_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[6:0] == SYM_M || m_tdata[6:0] == SYM_D
			|| m_tdata[6:0] == SYM_C || m_tdata[6:0] == SYM_L
			|| m_tdata[6:0] == SYM_X || m_tdata[6:0] == SYM_V
			|| m_tdata[6:0] == SYM_I)
		else $error("illegal symbol");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

endmodule

bind integer_to_roman_numeral i2r_checker u_i2r_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
